// ===== src/dtq_pkg.sv =====
// dtq_pkg: shared constants, codes and control/status structs of the deadline timer queue.
// No dependencies; imported by dtq_datapath, dtq_ctrl, the top level and dtq_checker.
package dtq_pkg;

	localparam int TIMER_SLOTS = 32;
	localparam int MAX_CATCHUP = 16;
	localparam int TAG_BITS    = 16;

	localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
	localparam int STEP_W = $clog2(MAX_CATCHUP + 1);
	localparam int TAG_W  = (TAG_BITS < 16) ? TAG_BITS : 16;

	localparam logic [1:0] CMD_BOOT  = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_SETEN = 2'd3;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_FIRE    = 3'd2;
	localparam logic [2:0] KIND_DUE     = 3'd3;
	localparam logic [2:0] KIND_COMPARE = 3'd4;

	localparam logic CFG_TPS    = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;

	typedef struct packed {
		logic [63:0]      dl;
		logic [TAG_W-1:0] tag;
	} ent_t;

	typedef struct packed {
		logic       ld_in;
		logic       ld_per;
		logic       ld_prod;
		logic       ld_dl;
		logic       boot;
		logic       seten;
		logic       per_adv;
		logic       resync;
		logic       div_start;
		logic       ins_rd;
		logic       ins_shift;
		logic       ins_put;
		logic       head_rd;
		logic       pop;
		logic       emit;
		logic [2:0] emit_kind;
		logic       emit_last;
		logic       cmp_direct;
	} dtq_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       empty;
		logic       pnext_le_now;
		logic       at_cap;
		logic       enabled;
		logic       head_due;
		logic       ins_gt;
		logic       pos_zero;
		logic       div_done;
	} dtq_stat_t;

	// circular slot index: (head + off) modulo TIMER_SLOTS
	function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, head} + {1'b0, off};
		if (s >= (IDX_W+1)'(TIMER_SLOTS))
			s = s - (IDX_W+1)'(TIMER_SLOTS);
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== src/dtq_ram.sv =====
// dtq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== src/dtq_div.sv =====
// dtq_div: restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on nothing; quotient is the low 32 bits.
module dtq_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	localparam int DIV_STEPS = 64;

	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[31:0];
endmodule

// ===== src/dtq_datapath.sv =====
// dtq_datapath: configuration, timer table (circular RAM), periodic state and result register.
// Depends on dtq_pkg, dtq_ram, dtq_div.
module dtq_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [1:0]          cmd,
	input  logic [63:0]         now,
	input  logic signed [31:0]  delay_seconds,
	input  logic [15:0]         timer_tag,
	input  logic                enable,
	input  dtq_pkg::dtq_cmd_t   c,
	output dtq_pkg::dtq_stat_t  st,
	output logic [2:0]          kind,
	output logic [15:0]         expired_tag,
	output logic [31:0]         seconds_since_boot,
	output logic [63:0]         compare_value,
	output logic                resynced,
	output logic                last
);
	import dtq_pkg::*;

	logic [31:0]      tps_q;
	logic [7:0]       ps_q;
	logic [1:0]       cmd_q;
	logic [63:0]      now_q;
	logic [31:0]      dsec_q;
	logic [TAG_W-1:0] tag_q;
	logic             en_in_q;
	logic [39:0]      per_q;
	logic [62:0]      prod_q;
	logic [63:0]      dl_q;
	logic [63:0]      boot_q;
	logic [63:0]      pnext_q;
	logic             en_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] pos_q;
	logic [STEP_W-1:0] steps_q;
	logic             rs_q;

	logic             we, re;
	logic [IDX_W-1:0] waddr, raddr;
	ent_t             wdata, rd;
	logic             div_done;
	logic [31:0]      quo;
	logic [63:0]      per64, cmp_next;
	logic [IDX_W-1:0] pos_idx, posm1_idx;

	assign per64     = {24'd0, per_q};
	assign pos_idx   = pos_q[IDX_W-1:0];
	assign posm1_idx = IDX_W'(pos_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= 32'd24000000;
			ps_q  <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TPS:    tps_q <= cfg_data;
				CFG_PERIOD: ps_q  <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	// item payload, arithmetic scratch and result register
	always_ff @(posedge clk) begin
		if (c.ld_in) begin
			cmd_q   <= cmd;
			now_q   <= now;
			dsec_q  <= delay_seconds;
			tag_q   <= timer_tag[TAG_W-1:0];
			en_in_q <= enable;
		end
		if (c.ld_per)
			per_q <= {8'd0, tps_q} * {32'd0, ps_q};
		if (c.ld_prod)
			prod_q <= {32'd0, dsec_q[30:0]} * {31'd0, tps_q};
		if (c.ld_dl)
			dl_q <= (dsec_q != 32'd0 && !dsec_q[31]) ? now_q + {1'b0, prod_q} : now_q;
		if (c.emit) begin
			kind               <= c.emit_kind;
			expired_tag        <= (c.emit_kind == KIND_DUE) ? 16'(rd.tag) : 16'd0;
			seconds_since_boot <= (c.emit_kind == KIND_FIRE && tps_q != 32'd0) ? quo : 32'd0;
			compare_value      <= (c.emit_kind == KIND_ADDED || c.emit_kind == KIND_COMPARE)
			                      ? (c.cmp_direct ? pnext_q : cmp_next) : 64'd0;
			resynced           <= (c.emit_kind == KIND_COMPARE) && rs_q;
			last               <= c.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q  <= '0;
			pnext_q <= '0;
			en_q    <= 1'b1;
			count_q <= '0;
			head_q  <= '0;
			pos_q   <= '0;
			steps_q <= '0;
			rs_q    <= 1'b0;
		end else begin
			if (c.ld_in) begin
				steps_q <= '0;
				rs_q    <= 1'b0;
			end
			if (c.ld_dl)
				pos_q <= count_q;
			if (c.ins_shift)
				pos_q <= pos_q - CNT_W'(1);
			if (c.ins_put)
				count_q <= count_q + CNT_W'(1);
			if (c.pop) begin
				head_q  <= slot_at(head_q, IDX_W'(1));
				count_q <= count_q - CNT_W'(1);
			end
			if (c.boot) begin
				boot_q  <= now_q;
				pnext_q <= now_q + per64;
				en_q    <= 1'b1;
				count_q <= '0;
			end
			if (c.seten) begin
				en_q <= en_in_q;
				if (en_in_q && pnext_q <= now_q)
					pnext_q <= now_q + per64;
			end
			if (c.per_adv) begin
				pnext_q <= pnext_q + per64;
				steps_q <= steps_q + STEP_W'(1);
			end
			if (c.resync) begin
				pnext_q <= now_q + per64;
				rs_q    <= 1'b1;
			end
		end
	end

	// table RAM ports
	always_comb begin
		we    = c.ins_shift | c.ins_put;
		waddr = slot_at(head_q, pos_idx);
		wdata = c.ins_put ? ent_t'{dl: dl_q, tag: tag_q} : rd;
		re    = c.ins_rd | c.head_rd;
		raddr = c.ins_rd ? slot_at(head_q, posm1_idx) : head_q;
	end

	dtq_ram #(.WIDTH($bits(ent_t)), .DEPTH(TIMER_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd)
	);

	dtq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (c.div_start),
		.dividend (pnext_q - boot_q),
		.divisor  (tps_q),
		.done     (div_done),
		.quotient (quo)
	);

	// next compare value; rd holds the head entry when this is used
	always_comb begin
		cmp_next = pnext_q;
		if (count_q != '0 && rd.dl < cmp_next)
			cmp_next = rd.dl;
		if (cmp_next <= now_q)
			cmp_next = now_q + 64'd1;
	end

	always_comb begin
		st.cmd          = cmd_q;
		st.full         = count_q >= CNT_W'(TIMER_SLOTS);
		st.empty        = count_q == '0;
		st.pnext_le_now = pnext_q <= now_q;
		st.at_cap       = steps_q >= STEP_W'(MAX_CATCHUP);
		st.enabled      = en_q;
		st.head_due     = rd.dl <= now_q;
		st.ins_gt       = rd.dl > dl_q;
		st.pos_zero     = pos_q == '0;
		st.div_done     = div_done;
	end
endmodule

// ===== src/dtq_ctrl.sv =====
// dtq_ctrl: sequencer of the deadline timer queue; drives datapath commands and handshakes.
// Depends on dtq_pkg.
module dtq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  dtq_pkg::dtq_stat_t st,
	output dtq_pkg::dtq_cmd_t  c
);
	import dtq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_PER, S_MUL_DL, S_DISPATCH, S_BOOT_EMIT, S_INS_RD, S_INS_CMP,
		S_INS_PUT, S_HEAD_RD, S_HEAD_CMP, S_TK_CHK, S_TK_DIV, S_POP_RD, S_POP_CMP,
		S_OUT_WAIT
	} state_t;

	state_t state_q, nxt, ret_d, ret_q;
	logic   last_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		c     = '0;
		nxt   = state_q;
		ret_d = S_IDLE;
		case (state_q)
			S_IDLE: if (in_valid) begin
				c.ld_in = 1'b1;
				nxt     = S_MUL_PER;
			end
			S_MUL_PER: begin
				c.ld_per = 1'b1;
				nxt      = S_MUL_DL;
			end
			S_MUL_DL: begin
				c.ld_prod = 1'b1;
				nxt       = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (st.cmd)
					CMD_BOOT: begin
						c.boot = 1'b1;
						nxt    = S_BOOT_EMIT;
					end
					CMD_ADD: if (st.full) begin
						c.emit      = 1'b1;
						c.emit_kind = KIND_FULL;
						c.emit_last = 1'b1;
					end else begin
						c.ld_dl = 1'b1;
						nxt     = S_INS_RD;
					end
					CMD_TICK: nxt = S_TK_CHK;
					default: begin
						c.seten = 1'b1;
						nxt     = S_HEAD_RD;
					end
				endcase
			end
			S_BOOT_EMIT: begin
				c.emit       = 1'b1;
				c.emit_kind  = KIND_COMPARE;
				c.emit_last  = 1'b1;
				c.cmp_direct = 1'b1;
			end
			S_INS_RD: if (st.pos_zero) begin
				nxt = S_INS_PUT;
			end else begin
				c.ins_rd = 1'b1;
				nxt      = S_INS_CMP;
			end
			S_INS_CMP: if (st.ins_gt) begin
				c.ins_shift = 1'b1;
				nxt         = S_INS_RD;
			end else begin
				nxt = S_INS_PUT;
			end
			S_INS_PUT: begin
				c.ins_put = 1'b1;
				nxt       = S_HEAD_RD;
			end
			S_HEAD_RD: begin
				c.head_rd = 1'b1;
				nxt       = S_HEAD_CMP;
			end
			S_HEAD_CMP: begin
				c.emit      = 1'b1;
				c.emit_kind = (st.cmd == CMD_ADD) ? KIND_ADDED : KIND_COMPARE;
				c.emit_last = 1'b1;
			end
			S_TK_CHK: if (!st.pnext_le_now) begin
				nxt = S_POP_RD;
			end else if (st.at_cap) begin
				c.resync = 1'b1;
				nxt      = S_POP_RD;
			end else if (st.enabled) begin
				c.div_start = 1'b1;
				nxt         = S_TK_DIV;
			end else begin
				c.per_adv = 1'b1;
			end
			S_TK_DIV: if (st.div_done) begin
				c.emit      = 1'b1;
				c.emit_kind = KIND_FIRE;
				c.per_adv   = 1'b1;
				ret_d       = S_TK_CHK;
			end
			S_POP_RD: if (st.empty) begin
				nxt = S_HEAD_CMP;
			end else begin
				c.head_rd = 1'b1;
				nxt       = S_POP_CMP;
			end
			// head entry already in the read register when not due
			S_POP_CMP: if (st.head_due) begin
				c.emit      = 1'b1;
				c.emit_kind = KIND_DUE;
				c.pop       = 1'b1;
				ret_d       = S_POP_RD;
			end else begin
				nxt = S_HEAD_CMP;
			end
			S_OUT_WAIT: if (out_ready)
				nxt = last_q ? S_IDLE : ret_q;
			default: nxt = S_IDLE;
		endcase
		if (c.emit)
			nxt = S_OUT_WAIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= nxt;
			if (c.emit) begin
				out_valid <= 1'b1;
				last_q    <= c.emit_last;
				ret_q     <= ret_d;
			end else if (state_q == S_OUT_WAIT && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

// ===== src/deadline_timer_queue_top.sv =====
// channel | signals                                             | beat moves when
// input   | cmd now delay_seconds timer_tag enable              | in_valid & in_ready
// output  | kind expired_tag seconds_since_boot compare_value   | out_valid & out_ready
//         | resynced last                                       |
// config  | cfg_we cfg_index cfg_data                           | cfg_we (no wait)
//
// One item at a time; output stalls hold the item in progress.
// Add: the insertion walk through the table RAM moves each timer with a later deadline up one slot.
// Tick: each periodic fire runs the bit-serial 64/32 divider; each due timer is read and popped.
// Reset is asynchronous; the table needs no clearing pass, boot empties it by count.
// in_ready is low from acceptance until the last result beat is taken.
// Depends on dtq_pkg, dtq_ctrl, dtq_datapath.
module deadline_timer_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [63:0]        now,
	input  logic signed [31:0] delay_seconds,
	input  logic [15:0]        timer_tag,
	input  logic               enable,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [15:0]        expired_tag,
	output logic [31:0]        seconds_since_boot,
	output logic [63:0]        compare_value,
	output logic               resynced,
	output logic               last
);
	import dtq_pkg::*;

	dtq_cmd_t  c;
	dtq_stat_t st;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.c         (c)
	);

	dtq_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.cmd                (cmd),
		.now                (now),
		.delay_seconds      (delay_seconds),
		.timer_tag          (timer_tag),
		.enable             (enable),
		.c                  (c),
		.st                 (st),
		.kind               (kind),
		.expired_tag        (expired_tag),
		.seconds_since_boot (seconds_since_boot),
		.compare_value      (compare_value),
		.resynced           (resynced),
		.last               (last)
	);
endmodule

// ===== src/dtq_checker.sv =====
// dtq_checker: port-level assertions for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg.
module dtq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [15:0] expired_tag,
	input logic [63:0] compare_value,
	input logic        last
);
	import dtq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(compare_value))
		else $error("result beat changed while stalled");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DUE |-> expired_tag == 16'd0)
		else $error("tag set on a result that is not a due timer");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ADDED || kind == KIND_FULL) |-> last)
		else $error("add result not final");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_FIRE || kind == KIND_DUE) |-> !last)
		else $error("tick ended without compare update");
endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.expired_tag   (expired_tag),
	.compare_value (compare_value),
	.last          (last)
);
